[design/skf_pkg.sv]
// Shared types and constants for the scalar Kalman filter core.
package skf_pkg;

   // Fixed-point word size and default fraction width
   localparam int DATA_W            = 32;
   localparam int DEFAULT_FRAC_BITS = 16;
   localparam int CSR_INDEX_W       = 2;

   // Control/status register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROCESS_NOISE      = 2'd0,
      CSR_MEASUREMENT_NOISE  = 2'd1,
      CSR_INITIAL_ESTIMATE   = 2'd2,
      CSR_INITIAL_COVARIANCE = 2'd3
   } csr_index_type;

   // Update sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL_EST,
      ST_MUL_COV,
      ST_UPD_COV,
      ST_OUT
   } state_type;

endpackage

[design/scalar_kalman_filter_core.sv]
// Scalar Kalman filter core: iterative gain divider and one shared multiplier.
// Each req word passes the states ST_DIV, ST_MUL_EST, ST_MUL_COV, ST_UPD_COV and ST_OUT in order.
// The core takes no new req word until the previous one is done; the restoring gain
// divider runs first, then the shared multiplier is used twice.
// A finished word waits in the rsp register while the next req word is taken.
// Synchronous reset loads Q=0.0001, R=0.3, estimate 200.0 (saturated if it does not fit), covariance 1.0.
module scalar_kalman_filter_core #(
   parameter int FRAC_BITS = skf_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [skf_pkg::DATA_W-1:0]  req_measurement,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [skf_pkg::DATA_W-1:0]  rsp_estimate,
   // register write port
   input  logic                               csr_write_enable,
   input  logic [skf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [skf_pkg::DATA_W-1:0]         csr_write_data
);
   import skf_pkg::*;

   // Derived widths and reset constants
   localparam int GAIN_W  = FRAC_BITS + 1;
   localparam int MUL_A_W = FRAC_BITS + 2;
   localparam int MUL_B_W = DATA_W + 2;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int CNT_W   = $clog2(FRAC_BITS + 1);
   localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [63:0] ONE_RAW  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] Q_RAW    = (ONE_RAW + 64'd5000) / 64'd10000;
   localparam logic [63:0] R_RAW    = (64'd3 * ONE_RAW + 64'd5) / 64'd10;
   localparam logic [63:0] EST_RAW  = 64'd200 << FRAC_BITS;
   localparam logic [DATA_W-1:0] RESET_Q = Q_RAW[DATA_W-1:0];
   localparam logic [DATA_W-1:0] RESET_R = R_RAW[DATA_W-1:0];
   localparam logic [DATA_W-1:0] RESET_P = ONE_RAW[DATA_W-1:0];
   localparam logic [DATA_W-1:0] RESET_X =
      (EST_RAW > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : EST_RAW[DATA_W-1:0];

   state_type state_ff, state_in;

   logic [DATA_W-1:0]         q_ff, q_in;
   logic [DATA_W-1:0]         r_ff, r_in;
   logic [DATA_W-1:0]         x0_ff, x0_in;
   logic [DATA_W-1:0]         p0_ff, p0_in;
   logic signed [DATA_W-1:0]  est_ff, est_in;
   logic [DATA_W-1:0]         cov_ff, cov_in;
   logic signed [DATA_W-1:0]  z_ff, z_in;
   logic [DATA_W+1:0]         rem_ff, rem_in;
   logic [DATA_W:0]           den_ff, den_in;
   logic [GAIN_W-1:0]         gain_ff, gain_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_estimate_ff, rsp_estimate_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_B_W-1:0] diff;
   logic                      div_ge;
   logic [DATA_W+1:0]         rem_sub;
   logic signed [MUL_B_W-1:0] est_sum;
   logic [DATA_W:0]           cov_sum;
   logic                      out_free;
   logic [GAIN_W-1:0]         one_minus_gain;

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = rsp_estimate_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // Divider step: one quotient bit per cycle, zero gain when P+R is zero
   assign div_ge  = (den_ff != '0) && (rem_ff >= {1'b0, den_ff});
   assign rem_sub = div_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

   // Shared multiplier operand select
   assign diff = {{2{z_ff[DATA_W-1]}}, z_ff} - {{2{est_ff[DATA_W-1]}}, est_ff};
   assign one_minus_gain = GAIN_ONE - gain_ff;
   always_comb begin
      if (state_ff == ST_MUL_COV) begin
         mul_a = {1'b0, one_minus_gain};
         mul_b = {2'b00, cov_ff};
      end else begin
         mul_a = {1'b0, gain_ff};
         mul_b = diff;
      end
   end
   assign prod_in = mul_a * mul_b;

   // Estimate and covariance post-multiply adds
   assign est_sum = {{2{est_ff[DATA_W-1]}}, est_ff} + prod_ff[FRAC_BITS+MUL_B_W-1:FRAC_BITS];
   assign cov_sum = {1'b0, prod_ff[FRAC_BITS+DATA_W-1:FRAC_BITS]} + {1'b0, q_ff};

   // Sequencer and datapath next values
   always_comb begin
      state_in        = state_ff;
      q_in            = q_ff;
      r_in            = r_ff;
      x0_in           = x0_ff;
      p0_in           = p0_ff;
      est_in          = est_ff;
      cov_in          = cov_ff;
      z_in            = z_ff;
      rem_in          = rem_ff;
      den_in          = den_ff;
      gain_in         = gain_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_estimate_in = rsp_estimate_ff;

      // register writes, taken while idle by the user's rule; the block itself does not enforce it
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROCESS_NOISE:      q_in = csr_write_data;
            CSR_MEASUREMENT_NOISE:  r_in = csr_write_data;
            CSR_INITIAL_ESTIMATE: begin
               x0_in  = csr_write_data;
               est_in = csr_write_data;
            end
            CSR_INITIAL_COVARIANCE: begin
               p0_in  = csr_write_data;
               cov_in = csr_write_data;
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               z_in     = req_measurement;
               rem_in   = {2'b00, cov_ff};
               den_in   = {1'b0, cov_ff} + {1'b0, r_ff};
               gain_in  = '0;
               cnt_in   = CNT_W'(FRAC_BITS);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            gain_in = {gain_ff[GAIN_W-2:0], div_ge};
            rem_in  = {rem_sub[DATA_W:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_MUL_EST;
            end
         end
         ST_MUL_EST: begin
            state_in = ST_MUL_COV;
         end
         ST_MUL_COV: begin
            est_in   = est_sum[DATA_W-1:0];
            state_in = ST_UPD_COV;
         end
         ST_UPD_COV: begin
            cov_in   = cov_sum[DATA_W] ? '1 : cov_sum[DATA_W-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_estimate_in = est_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         q_ff         <= RESET_Q;
         r_ff         <= RESET_R;
         x0_ff        <= RESET_X;
         p0_ff        <= RESET_P;
         est_ff       <= RESET_X;
         cov_ff       <= RESET_P;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         x0_ff        <= x0_in;
         p0_ff        <= p0_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
      end
   end

   // Working registers, no reset needed
   always_ff @(posedge clock) begin
      z_ff            <= z_in;
      rem_ff          <= rem_in;
      den_ff          <= den_in;
      gain_ff         <= gain_in;
      cnt_ff          <= cnt_in;
      prod_ff         <= prod_in;
      rsp_estimate_ff <= rsp_estimate_in;
   end

   // Accepted word starts the divider
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIV))
      else $error("accepted word did not start gain division");

   // Gain never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_EST) |-> (gain_ff <= GAIN_ONE))
      else $error("gain above one");

   // Result loads the output register once it is free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished word not delivered");

   // Covariance after update includes process noise
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD_COV && !csr_write_enable) |=> (cov_ff >= q_ff))
      else $error("covariance below process noise");

   // Busy sequencer never takes a word
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("ready while busy");

endmodule

[tb/sv/tb_scalar_kalman_filter_core.sv]
// Self-checking testbench for the scalar Kalman filter core with a built-in predictor.
`timescale 1ns / 100ps

module tb_scalar_kalman_filter_core;
   import skf_pkg::*;

   localparam int FRAC_BITS        = DEFAULT_FRAC_BITS;
   localparam logic [63:0] ONE_FX  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] MAX_U32 = 64'hFFFF_FFFF;
   localparam int RANDOM_PHASES    = 8;
   localparam int WORDS_PER_PHASE  = 235;
   localparam int SETTLE_CYCLES    = FRAC_BITS + 10;
   localparam int CYCLE_LIMIT      = 1_500_000;

   // Clock, reset and DUT ports; the driven inputs are known from time zero
   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_measurement  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic signed [DATA_W-1:0] rsp_estimate;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index        = CSR_PROCESS_NOISE;
   logic [DATA_W-1:0]        csr_write_data   = '0;

   // Filter state mirrored by the predictor
   logic [31:0]              noise_q;
   logic [31:0]              noise_r;
   logic signed [31:0]       est_state;
   logic [31:0]              cov_state;

   logic signed [31:0]       pending_measurements[$];
   logic signed [31:0]       expected_estimates[$];

   int                       failures       = 0;
   int                       words_accepted = 0;
   int                       estimates_seen = 0;
   int                       phases_run     = 0;
   int                       cycle_count    = 0;
   int                       burst_left     = 1;
   int                       gap_left       = 0;
   int                       stall_mode     = 0;
   int                       stall_left     = 0;
   logic signed [31:0]       phase_center   = '0;

   always #2 clock = ~clock;

   scalar_kalman_filter_core #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_estimate    (rsp_estimate),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // One filter step: gain, estimate update, covariance update with saturation
   function automatic logic signed [31:0] kalman_update(input logic signed [31:0] z);
      logic [63:0]        p;
      logic [63:0]        den;
      logic [63:0]        gain;
      logic [63:0]        np;
      logic signed [63:0] zx;
      logic signed [63:0] xx;
      logic signed [63:0] nx;
      p    = {32'd0, cov_state};
      den  = p + {32'd0, noise_r};
      gain = (den != 0) ? (p << FRAC_BITS) / den : 64'd0;
      if (gain > ONE_FX) gain = ONE_FX;
      zx   = z;
      xx   = est_state;
      // arithmetic shift floors toward minus infinity
      nx   = xx + (($signed(gain) * (zx - xx)) >>> FRAC_BITS);
      np   = (((ONE_FX - gain) * p) >> FRAC_BITS) + {32'd0, noise_q};
      if (np > MAX_U32) np = MAX_U32;
      est_state = nx[31:0];
      cov_state = np[31:0];
      return nx[31:0];
   endfunction

   // Power-on register values; the estimate saturates if 200.0 does not fit
   task automatic load_reset_state();
      logic [63:0] est;
      est       = 64'd200 << FRAC_BITS;
      if (est > 64'h7FFF_FFFF) est = 64'h7FFF_FFFF;
      noise_q   = 32'((ONE_FX + 64'd5000) / 64'd10000);
      noise_r   = 32'((64'd3 * ONE_FX + 64'd5) / 64'd10);
      est_state = est[31:0];
      cov_state = ONE_FX[31:0];
   endtask

   // Register write, mirrored into the predictor at once (block is idle)
   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_PROCESS_NOISE:      noise_q   = data;
         CSR_MEASUREMENT_NOISE:  noise_r   = data;
         CSR_INITIAL_ESTIMATE:   est_state = data;
         CSR_INITIAL_COVARIANCE: cov_state = data;
         default: ;
      endcase
   endtask

   task automatic program_filter(input logic [31:0] q, input logic [31:0] r,
                                 input logic [31:0] x0, input logic [31:0] p0);
      write_reg(CSR_PROCESS_NOISE, q);
      write_reg(CSR_MEASUREMENT_NOISE, r);
      write_reg(CSR_INITIAL_ESTIMATE, x0);
      write_reg(CSR_INITIAL_COVARIANCE, p0);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      phases_run++;
   endtask

   // Sender holds off until the queue has drained and every estimate is back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_measurements.size() != 0 || req_valid || expected_estimates.size() != 0);
   endtask

   // Unsigned register value: mostly realistic, sometimes an extreme
   function automatic logic [31:0] pick_unsigned();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(0, 4096);
         3:       return $urandom_range(0, 1 << 20);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic signed [31:0] pick_measurement();
      case ($urandom_range(0, 9))
         0:       return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         1, 2, 3: return $urandom();
         // noisy samples around a per-phase operating point
         default: return phase_center + $signed($urandom_range(0, 1 << 17)) - 32'sd65536;
      endcase
   endfunction

   // Driver: bursts of words separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_estimates.push_back(kalman_update(req_measurement));
            words_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_measurements.size() > 0) begin
               req_valid       <= 1'b1;
               req_measurement <= pending_measurements.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  case ($urandom_range(0, 3))
                     0:       gap_left = 0;
                     3:       gap_left = $urandom_range(9, 40);
                     default: gap_left = $urandom_range(1, 8);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure: always ready, random, or mostly stalled
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 1) != 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Monitor: compare each estimate word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         estimates_seen++;
         if (expected_estimates.size() == 0) begin
            $error("estimate word %0d with no prediction pending", rsp_estimate);
            failures++;
         end else if (rsp_estimate !== expected_estimates[0]) begin
            $error("estimate mismatch: expected %0d, actual %0d",
                   expected_estimates[0], rsp_estimate);
            failures++;
            void'(expected_estimates.pop_front());
         end else begin
            void'(expected_estimates.pop_front());
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      load_reset_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: field extremes and the reset estimate itself
      pending_measurements = '{32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd1,
                               32'sd13107200, 32'sh0001_0000, 32'shFFFF_0000};
      wait_drained();

      // Zero measurement noise: gain one, estimate jumps to z; then P and R
      // both zero so the estimate holds
      program_filter(32'd0, 32'd0, 32'd0, 32'h0001_0000);
      pending_measurements = '{32'sd5, 32'sh8000_0000, 32'sh7FFF_FFFF};
      wait_drained();

      // All-ones noise and covariance: covariance saturates
      program_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      pending_measurements = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0};
      wait_drained();

      // Smallest legal R with zero covariance: gain zero
      program_filter(32'd0, 32'd1, 32'h7FFF_FFFF, 32'd0);
      pending_measurements = '{32'sh8000_0000, 32'sd0};
      wait_drained();

      // Random phases, each with its own register settings
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         logic [31:0] r_pick;
         logic [31:0] x_pick;
         r_pick = pick_unsigned();
         if (r_pick == 0) r_pick = 32'd1;
         case ($urandom_range(0, 3))
            0:       x_pick = 32'h8000_0000;
            1:       x_pick = 32'h7FFF_FFFF;
            default: x_pick = $urandom();
         endcase
         phase_center = $urandom();
         program_filter(pick_unsigned(), r_pick, x_pick, pick_unsigned());
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            pending_measurements.push_back(pick_measurement());
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d register settings including zero and all-ones noise,", phases_run);
      $display("%0d measurement words sent, %0d estimate words checked.",
               words_accepted, estimates_seen);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
